// ===== rtl/core/fepm_pkg.sv =====
// Shared types and constants of the fuel economy pulse meter.
package fepm_pkg;

  localparam int TIMER_BITS_DEF = 16;
  localparam int SUM_BITS_DEF   = 18;

  localparam int WIN_W   = 18;
  localparam int TMO_W   = 16;
  localparam int LIM_W   = 6;
  localparam int CNT_W   = 17;
  localparam int SPD_W   = 27;
  localparam int FUEL_W  = 16;
  localparam int HIGH_W  = 16;
  localparam int HSUM_W  = 18;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 18;
  localparam int QUO_W   = 26;  // 1000 * 65535 fits in 26 bits

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;
  localparam logic [WIN_W-1:0] WINDOW_RST = 18'd125000;
  localparam logic [TMO_W-1:0] TIMEOUT_RST = 16'd20000;
  localparam logic [LIM_W-1:0] INJ_LIM_RST = 6'd20;
  localparam logic [LIM_W-1:0] SPD_LIM_RST = 6'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW  = 2'd0,
    REG_TIMEOUT = 2'd1,
    REG_INJ_LIM = 2'd2,
    REG_SPD_LIM = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FUEL,
    ST_DIVIDE,
    ST_OUT
  } ctrl_state_t;

  // controller to datapath
  typedef struct packed {
    logic tick;
    logic calc_fuel;
    logic div_start;
    logic div_step;
    logic finish;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic win_done;
    logic div_needed;
    logic div_last;
  } dp_status_t;

endpackage

// ===== rtl/core/fepm_ctrl.sv =====
// Controller sequencing ticks, result arithmetic and output hand-off.
module fepm_ctrl
  import fepm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_load,
  input  logic       out_free,
  output dp_cmd_t    cmd,
  input  dp_status_t status
);

  ctrl_state_t state, state_next;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && status.win_done) state_next = ST_FUEL;
      end
      ST_FUEL:   state_next = status.div_needed ? ST_DIVIDE : ST_OUT;
      ST_DIVIDE: if (status.div_last) state_next = ST_OUT;
      ST_OUT:    if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // outputs
  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_load = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.tick = in_valid;
      end
      ST_FUEL: begin
        cmd.calc_fuel = 1'b1;
        cmd.div_start = status.div_needed;
      end
      ST_DIVIDE: cmd.div_step = 1'b1;
      ST_OUT: begin
        out_load = out_free;
        cmd.finish = out_free;
      end
      default: ;
    endcase
  end

  a_no_tick_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !cmd.tick) else $error("tick while busy");
  a_fuel_follows: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && in_valid && status.win_done) |=> state == ST_FUEL)
    else $error("window end lost");
  a_load_once: assert property (@(posedge clk) disable iff (rst)
    out_load |=> !out_load) else $error("double load");

endmodule

// ===== rtl/core/fepm_dp.sv =====
// Datapath: pulse timers, window sums, result arithmetic and divider.
module fepm_dp
  import fepm_pkg::*;
#(
  parameter int TIMER_BITS = TIMER_BITS_DEF,
  parameter int SUM_BITS   = SUM_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [WIN_W-1:0]  window_ticks,
  input  logic [TMO_W-1:0]  low_timeout_ticks,
  input  logic [LIM_W-1:0]  inj_no_pulse_limit,
  input  logic [LIM_W-1:0]  spd_no_pulse_limit,
  input  logic              inj_level,
  input  logic              spd_level,
  input  dp_cmd_t           cmd,
  output dp_status_t        status,
  output logic [HIGH_W-1:0] r_high,
  output logic [HSUM_W-1:0] r_hsum,
  output logic [CNT_W-1:0]  r_count,
  output logic [SPD_W-1:0]  r_speed,
  output logic [FUEL_W-1:0] r_fuel,
  output logic [FUEL_W-1:0] r_econ,
  output logic              r_inj_abort,
  output logic              r_sat
);

  localparam logic [SUM_BITS-1:0] SUM_MAX = '1;
  localparam int DIV_STEPS = QUO_W;
  localparam int DC_W = $clog2(DIV_STEPS + 1);

  logic meas_inj, waiting_low;
  logic [TIMER_BITS-1:0] pulse_timer, high_width, low_width;
  logic [SUM_BITS-1:0] window_sum, high_sum;
  logic [LIM_W-1:0] zero_cnt;
  logic [CNT_W-1:0] speed_pulses;
  logic [SPD_W-1:0] speed_value;
  logic [FUEL_W-1:0] fuel_kept, econ_kept;
  logic inj_abort_r;

  // combinational tick evaluation
  logic level, pulse_done, new_wait;
  logic [TIMER_BITS-1:0] timer_inc, hw_eff, lw_eff;
  logic [SUM_BITS:0] wsum_add, hsum_add;
  logic [SUM_BITS-1:0] wsum_new, hsum_new;
  logic [TIMER_BITS:0] pulse_len;
  logic zero_pulse, spd_abort, inj_abort, spd_end, inj_end;
  logic [CNT_W-1:0] cnt_new;

  always_comb begin
    level = meas_inj ? inj_level : spd_level;
    timer_inc = pulse_timer + 1'b1;
    hw_eff = waiting_low ? high_width : pulse_timer;
    new_wait = waiting_low || !level;
    lw_eff = low_width;
    pulse_done = 1'b0;
    if (new_wait) begin
      if (level && waiting_low) begin
        lw_eff = pulse_timer;
        pulse_done = 1'b1;
      end else if (!level) begin
        // first low tick counts as one when entering low phase
        pulse_done = ({{(32-TIMER_BITS){1'b0}}, (waiting_low ? timer_inc
                       : {{(TIMER_BITS-1){1'b0}}, 1'b1})})
                     > {16'd0, low_timeout_ticks};
      end
    end
    pulse_len = {1'b0, hw_eff} + {1'b0, lw_eff};
    wsum_add = {1'b0, window_sum} + (SUM_BITS + 1)'(pulse_len);
    if (TIMER_BITS + 1 > SUM_BITS + 1 && (pulse_len >> SUM_BITS) != 0)
      wsum_add = '1;
    wsum_new = wsum_add[SUM_BITS] ? SUM_MAX : wsum_add[SUM_BITS-1:0];
    hsum_add = {1'b0, high_sum} + (SUM_BITS + 1)'(hw_eff);
    if (TIMER_BITS > SUM_BITS && (hw_eff >> SUM_BITS) != 0) hsum_add = '1;
    hsum_new = hsum_add[SUM_BITS] ? SUM_MAX : hsum_add[SUM_BITS-1:0];
    cnt_new = (speed_pulses == COUNT_MAX) ? COUNT_MAX : speed_pulses + 1'b1;
    zero_pulse = (hw_eff == '0);
    spd_abort = zero_pulse && (zero_cnt >= spd_no_pulse_limit);
    inj_abort = zero_pulse && (zero_cnt >= inj_no_pulse_limit);
    spd_end = !spd_abort && ({{(32-SUM_BITS){1'b0}}, wsum_new}
              >= {14'd0, window_ticks});
    inj_end = inj_abort || ({{(32-SUM_BITS){1'b0}}, wsum_new}
              >= {14'd0, window_ticks});
  end

  assign status.win_done = meas_inj && pulse_done && inj_end;

  // speed scaling: count * 73476 / 100 = count * 734 + count * 19 / 25,
  // the division by 25 as reciprocal multiply; speed sums registered parts
  localparam logic [26:0] SPD_RECIP = 27'd102005490;  // 19 * ceil(2^27 / 25)
  logic [CNT_W+27-1:0] spd_frac_prod;
  logic [SPD_W-1:0] spd_base, spd_base_r;
  logic [CNT_W-1:0] spd_frac_r;
  logic spd_load;
  assign spd_frac_prod = (CNT_W + 27)'(cnt_new) * (CNT_W + 27)'(SPD_RECIP);
  assign spd_base = SPD_W'(cnt_new) * SPD_W'(10'd734);

  // fuel scaling: sum * 117 / 625 by reciprocal multiply, saturated
  localparam int FUEL_K = SUM_BITS + 17;
  localparam int FUEL_PW = SUM_BITS + FUEL_K;
  localparam longint FUEL_RECIP = ((64'd1 << FUEL_K) + 64'd624) / 64'd625 * 64'd117;
  logic [FUEL_PW-1:0] fuel_prod;
  logic [SUM_BITS-1:0] fuel_div;
  logic [FUEL_W-1:0] fuel_sat;
  assign fuel_prod = FUEL_PW'(high_sum) * FUEL_PW'(FUEL_RECIP);
  assign fuel_div = fuel_prod[FUEL_PW-1:FUEL_K];
  assign fuel_sat = ((fuel_div >> FUEL_W) != '0) ? '1 : FUEL_W'(fuel_div);

  // restoring divider for 1000 * fuel / speed
  logic [QUO_W-1:0] div_q;
  logic [SPD_W:0] div_rem;
  logic [DC_W-1:0] div_cnt;
  logic [SPD_W:0] rem_sh, rem_sub;
  assign rem_sh = {div_rem[SPD_W-1:0], div_q[QUO_W-1]};
  assign rem_sub = rem_sh - {1'b0, speed_value};
  assign status.div_needed = !inj_abort_r && (speed_value != '0);
  assign status.div_last = (div_cnt == DC_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      meas_inj <= 1'b0;
      waiting_low <= 1'b0;
      pulse_timer <= '0;
      high_width <= '0;
      low_width <= '0;
      window_sum <= '0;
      high_sum <= '0;
      zero_cnt <= '0;
      speed_pulses <= '0;
      speed_value <= '0;
      fuel_kept <= '0;
      econ_kept <= '0;
      inj_abort_r <= 1'b0;
      r_sat <= 1'b0;
      div_cnt <= '0;
      spd_load <= 1'b0;
    end else begin
      // finish the speed scaling started at the speed window end
      spd_load <= 1'b0;
      if (spd_load) speed_value <= spd_base_r + SPD_W'(spd_frac_r);
      if (cmd.tick) begin
        if (!new_wait) begin
          pulse_timer <= timer_inc;
        end else begin
          if (!waiting_low) high_width <= pulse_timer;
          waiting_low <= !pulse_done;
          low_width <= lw_eff;
          pulse_timer <= pulse_done ? '0 : (waiting_low ? timer_inc : TIMER_BITS'(1));
          if (pulse_done) begin
            if (!meas_inj) begin
              window_sum <= wsum_new;
              speed_pulses <= cnt_new;
              if (zero_pulse && !spd_abort) zero_cnt <= zero_cnt + 1'b1;
              if (spd_abort || spd_end) begin
                meas_inj <= 1'b1;
                waiting_low <= 1'b0;
                high_width <= '0;
                low_width <= '0;
                window_sum <= '0;
                high_sum <= '0;
                zero_cnt <= '0;
                if (spd_abort) begin
                  speed_pulses <= '0;
                end else begin
                  spd_load <= 1'b1;
                  spd_base_r <= spd_base;
                  spd_frac_r <= spd_frac_prod[CNT_W+26:27];
                end
              end
            end else begin
              if (zero_pulse && !inj_abort) zero_cnt <= zero_cnt + 1'b1;
              if (!inj_abort) begin
                window_sum <= wsum_new;
                high_sum <= hsum_new;
              end
              high_width <= hw_eff;
              inj_abort_r <= inj_abort;
            end
          end
        end
      end
      if (cmd.calc_fuel) begin
        r_sat <= 1'b0;
        if (!inj_abort_r) begin
          fuel_kept <= fuel_sat;
          if (speed_value == '0) begin
            econ_kept <= '1;
            r_sat <= 1'b1;
          end
        end
      end
      if (cmd.div_start) begin
        div_cnt <= DC_W'(DIV_STEPS);
        div_rem <= '0;
        div_q <= QUO_W'({fuel_sat, 10'd0}) - QUO_W'({fuel_sat, 4'd0})
               - QUO_W'({fuel_sat, 3'd0});
      end else if (cmd.div_step) begin
        div_cnt <= div_cnt - 1'b1;
        if (!rem_sub[SPD_W]) begin
          div_rem <= rem_sub;
          div_q <= {div_q[QUO_W-2:0], 1'b1};
        end else begin
          div_rem <= rem_sh;
          div_q <= {div_q[QUO_W-2:0], 1'b0};
        end
        if (status.div_last) begin
          if (({div_q[QUO_W-2:0], !rem_sub[SPD_W]} >> FUEL_W) != '0) begin
            econ_kept <= '1;
            r_sat <= 1'b1;
          end else begin
            econ_kept <= FUEL_W'({div_q[QUO_W-2:0], !rem_sub[SPD_W]});
          end
        end
      end
      if (cmd.finish) begin
        meas_inj <= 1'b0;
        waiting_low <= 1'b0;
        pulse_timer <= '0;
        high_width <= '0;
        low_width <= '0;
        window_sum <= '0;
        high_sum <= '0;
        zero_cnt <= '0;
        speed_pulses <= '0;
      end
    end
  end

  assign r_high = HIGH_W'(high_width);
  assign r_hsum = HSUM_W'(high_sum);
  assign r_count = speed_pulses;
  assign r_speed = speed_value;
  assign r_fuel = fuel_kept;
  assign r_econ = econ_kept;
  assign r_inj_abort = inj_abort_r;

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> div_cnt == DC_W'(DIV_STEPS)) else $error("divider not loaded");
  a_window_limit: assert property (@(posedge clk) disable iff (rst)
    $rose(meas_inj) |-> window_sum == '0) else $error("window not cleared");
  a_abort_no_sum: assert property (@(posedge clk) disable iff (rst)
    (cmd.tick && status.win_done && inj_abort) |=> high_sum == $past(high_sum))
    else $error("aborted window summed");

endmodule

// ===== rtl/core/fuel_economy_pulse_meter_core.sv =====
// Ticks: a tick without a window end leaves ready high.
// Injector window end: fuel scale, then the restoring divider (1000 * ml/h / speed),
// then the result loads into the output register.
// Throughput: one tick per cycle, stalled at each injector window end (shorter
// when the divider is skipped), longer while the output is held.
// Reset (rst, synchronous): registers to defaults, speed window first, outputs empty.
module fuel_economy_pulse_meter_core
  import fepm_pkg::*;
#(
  parameter int TIMER_BITS = TIMER_BITS_DEF,
  parameter int SUM_BITS   = SUM_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // [0] inj_level, [1] spd_level
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [15:0] inj_last_high_ticks, [33:16] inj_high_sum_ticks, [50:34] spd_pulse_count,
  // [77:51] speed_centi_kmh, [93:78] fuel_ml_per_h, [109:94] fuel_centil_per_100km,
  // [110] inj_aborted, [111] spd_aborted, [112] economy_saturated
  output logic [119:0]          m_tdata
);

  logic [WIN_W-1:0] window_ticks;
  logic [TMO_W-1:0] low_timeout_ticks;
  logic [LIM_W-1:0] inj_lim, spd_lim;

  // hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      window_ticks <= WINDOW_RST;
      low_timeout_ticks <= TIMEOUT_RST;
      inj_lim <= INJ_LIM_RST;
      spd_lim <= SPD_LIM_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_WINDOW:  window_ticks <= cfg_data;
        REG_TIMEOUT: low_timeout_ticks <= cfg_data[TMO_W-1:0];
        REG_INJ_LIM: inj_lim <= cfg_data[LIM_W-1:0];
        REG_SPD_LIM: spd_lim <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  dp_cmd_t cmd;
  dp_status_t status;
  logic out_load, out_free, in_ready;
  logic [HIGH_W-1:0] r_high;
  logic [HSUM_W-1:0] r_hsum;
  logic [CNT_W-1:0] r_count;
  logic [SPD_W-1:0] r_speed;
  logic [FUEL_W-1:0] r_fuel, r_econ;
  logic r_inj_abort, r_sat;

  fepm_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_tvalid), .in_ready(in_ready),
    .out_load(out_load), .out_free(out_free), .cmd(cmd), .status(status)
  );

  fepm_dp #(.TIMER_BITS(TIMER_BITS), .SUM_BITS(SUM_BITS)) u_dp (
    .clk(clk), .rst(rst), .window_ticks(window_ticks),
    .low_timeout_ticks(low_timeout_ticks), .inj_no_pulse_limit(inj_lim),
    .spd_no_pulse_limit(spd_lim), .inj_level(s_tdata[0]), .spd_level(s_tdata[1]),
    .cmd(cmd), .status(status), .r_high(r_high), .r_hsum(r_hsum),
    .r_count(r_count), .r_speed(r_speed), .r_fuel(r_fuel), .r_econ(r_econ),
    .r_inj_abort(r_inj_abort), .r_sat(r_sat)
  );

  assign s_tready = in_ready;
  assign out_free = !m_tvalid || m_tready;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {7'd0, r_sat, (r_count == '0), r_inj_abort, r_econ, r_fuel,
                  r_speed, r_count, r_hsum, r_high};
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> $stable(m_tdata)) else $error("payload changed");
  a_keep: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid) else $error("valid dropped");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!m_tvalid || m_tready)) else $error("result overwritten");

endmodule
